// ===== sv/qcws_pkg.sv =====
// ----------------------------------------------------------------------------
// qcws_pkg
// Shared constants, item types and control codes of the QC window statistics
// block.
// ----------------------------------------------------------------------------
package qcws_pkg;

  localparam int CHANNELS     = 10;
  localparam int WINDOW_DEPTH = 20;

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W     = $clog2(WINDOW_DEPTH);
  localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
  localparam int MEM_DEPTH = CHANNELS * WINDOW_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int S_W    = 32 + CNT_W;        // signed window sum
  localparam int EW     = 32 + CNT_W;        // |n*x - sum|
  localparam int HW     = (EW + 1) / 2;      // half width for partial products
  localparam int E_W    = 2 * EW + CNT_W;    // sum of squared deviations
  localparam int K_W    = 3 * CNT_W;         // n*n*(n-1)
  localparam int DIV_NW = E_W;
  localparam int DIV_DW = 33;
  localparam int SQ_W   = 62;
  localparam int SD_W   = 31;
  localparam int CVP_W  = SD_W + 23;

  localparam logic [22:0] CV_SCALE = 23'd6553600;  // 100.0 in Q16.16

  typedef enum logic [1:0] {
    KIND_SUBMIT   = 2'd0,
    KIND_QUERY    = 2'd1,
    KIND_SETUP    = 2'd2,
    KIND_RESERVED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RES_ACK     = 3'd0,
    RES_REJECT  = 3'd1,
    RES_NONE    = 3'd2,
    RES_BADQ    = 3'd3,
    RES_INVALID = 3'd4,
    RES_STATS   = 3'd5
  } res_e;

  typedef enum logic [1:0] {
    DIV_MEAN  = 2'd0,
    DIV_STD   = 2'd1,
    DIV_CV    = 2'd2,
    DIV_RATIO = 2'd3
  } div_sel_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         channel;
    logic signed [31:0] sample_value;
    logic signed [31:0] target_value;
    logic [30:0]        margin_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         sample_count;
    logic signed [31:0] mean_value;
    logic [30:0]        std_dev;
    logic signed [31:0] cv_percent;
    logic signed [31:0] target_ratio;
  } out_item_t;

  typedef struct packed {
    logic     load_item;
    logic     do_setup;
    logic     do_submit;
    logic     rd_start;
    logic     sum_run;
    logic     dev_start;
    logic     dev_run;
    logic     div_start;
    logic     div_take;
    div_sel_e div_sel;
    logic     sqrt_start;
    logic     sd_take;
    logic     out_load;
    res_e     res;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       ch_ok;
    logic       in_range;
    logic       n_zero;
    logic       stats_ok;
    logic       sum_done;
    logic       dev_done;
    logic       div_busy;
    logic       sqrt_busy;
    logic       out_free;
  } stat_t;

endpackage

// ===== sv/qcws_if.sv =====
// ----------------------------------------------------------------------------
// qcws_if
// Valid/ready channels carrying command items in and result items out.
// ----------------------------------------------------------------------------
interface qcws_in_if;
  import qcws_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qcws_out_if;
  import qcws_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/qcws_div.sv =====
// ----------------------------------------------------------------------------
// qcws_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qcws_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [qcws_pkg::DIV_NW-1:0]  num_i,
  input  logic [qcws_pkg::DIV_DW-1:0]  den_i,
  output logic                         busy_o,
  output logic [qcws_pkg::DIV_NW-1:0]  quot_o
);
  import qcws_pkg::*;

  localparam int IT_W = $clog2(DIV_NW + 1);

  logic              busy_q;
  logic [IT_W-1:0]   it_q;
  logic [DIV_NW-1:0] nq_q;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, nq_q[DIV_NW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      it_q   <= IT_W'(DIV_NW);
    end else if (busy_q) begin
      busy_q <= (it_q != IT_W'(1));
      it_q   <= it_q - IT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      nq_q  <= {nq_q[DIV_NW-2:0], ge};
      rem_q <= ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = nq_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");

endmodule

// ===== sv/qcws_sqrt.sv =====
// ----------------------------------------------------------------------------
// qcws_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module qcws_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [qcws_pkg::SQ_W-1:0]   x_i,
  output logic                        busy_o,
  output logic [qcws_pkg::SD_W-1:0]   root_o
);
  import qcws_pkg::*;

  logic            busy_q;
  logic [SQ_W-1:0] x_q;
  logic [SQ_W-1:0] r_q;
  logic [SQ_W-1:0] sbit_q;
  logic [SQ_W:0]   trial;
  logic            fits;

  assign trial = {1'b0, r_q} + {1'b0, sbit_q};
  assign fits  = {1'b0, x_q} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q) begin
      busy_q <= !sbit_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      r_q    <= '0;
      sbit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_q) begin
      if (fits) begin
        x_q <= x_q - trial[SQ_W-1:0];
        r_q <= (r_q >> 1) + sbit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign root_o = r_q[SD_W-1:0];

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("square root did not start");

endmodule

// ===== sv/qcws_dpath.sv =====
// ----------------------------------------------------------------------------
// qcws_dpath
// Channel tables, sample memory, accumulators, shared divider and square
// root, and the result register.
// ----------------------------------------------------------------------------
module qcws_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qcws_pkg::cmd_t       cmd_i,
  output qcws_pkg::stat_t      stat_o,
  input  qcws_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output qcws_pkg::out_item_t  out_data_o
);
  import qcws_pkg::*;

  localparam logic [2:0] PH_READ = 3'd0;
  localparam logic [2:0] PH_DIFF = 3'd1;
  localparam logic [2:0] PH_HH   = 3'd2;
  localparam logic [2:0] PH_HL   = 3'd3;
  localparam logic [2:0] PH_LL   = 3'd4;
  localparam logic [2:0] PH_ACC  = 3'd5;

  in_item_t           item_q;
  logic signed [31:0] target_q [CHANNELS];
  logic [30:0]        margin_q [CHANNELS];
  logic [CNT_W-1:0]   count_q  [CHANNELS];
  logic [PTR_W-1:0]   wpos_q   [CHANNELS];
  logic [31:0]        mem_q    [MEM_DEPTH];
  logic signed [31:0] rd_q;

  logic [CNT_W-1:0]   n_q;
  logic [CNT_W-1:0]   idx_q;
  logic               rdv_q;
  logic [2:0]         ph_q;
  logic signed [S_W-1:0] s1_q;
  logic signed [31:0] mean_q;
  logic [EW-1:0]      e_q;
  logic [2*HW-1:0]    prod_q;
  logic [E_W-1:0]     acc_q;
  logic [2*CNT_W-1:0] nn_q;
  logic [K_W-1:0]     k_q;
  logic               sat_q;
  logic [SD_W-1:0]    sd_q;
  logic [CVP_W-1:0]   cvp_q;
  logic signed [31:0] cv_q;
  logic signed [31:0] ratio_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic               ch_ok;
  logic [CH_W-1:0]    chi;
  logic signed [31:0] tgt;
  logic [CNT_W-1:0]   cnt;
  logic [PTR_W-1:0]   wp;
  logic signed [33:0] smp34, lo34, hi34, t34, m34;
  logic               in_range;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic               wr_en;

  logic signed [EW:0] nx, diff;
  logic [HW-1:0]      mul_a, mul_b;
  logic [S_W-1:0]     s1_mag;
  logic [31:0]        m_mag, t_mag;
  logic [DIV_NW-1:0]  div_num, quot;
  logic [DIV_DW-1:0]  div_den;
  logic               div_neg, div_busy;
  logic               sqrt_busy;
  logic [SD_W-1:0]    root, sdn;
  out_item_t          res;

  function automatic logic [31:0] sat_signed(input logic [DIV_NW-1:0] q, input logic neg);
    logic        over;
    logic [31:0] r;
    over = |q[DIV_NW-1:31];
    if (!neg) r = over ? 32'h7FFF_FFFF : q[31:0];
    else if (over && (q != (DIV_NW'(1) << 31))) r = 32'h8000_0000;
    else r = -q[31:0];
    return r;
  endfunction

  // channel lookup and limit check
  assign ch_ok = 32'(item_q.channel) < 32'(CHANNELS);
  assign chi   = item_q.channel[CH_W-1:0];
  assign tgt   = target_q[chi];
  assign cnt   = count_q[chi];
  assign wp    = wpos_q[chi];
  assign smp34 = 34'(item_q.sample_value);
  assign t34   = 34'(tgt);
  assign m34   = $signed({3'b000, margin_q[chi]});
  assign lo34  = t34 - m34;
  assign hi34  = t34 + m34;
  assign in_range = (smp34 >= lo34) && (smp34 <= hi34);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        target_q[i] <= '0;
        margin_q[i] <= '0;
        count_q[i]  <= '0;
        wpos_q[i]   <= '0;
      end
    end else if (cmd_i.do_setup && ch_ok) begin
      target_q[chi] <= item_q.target_value;
      margin_q[chi] <= item_q.margin_value;
      count_q[chi]  <= '0;
      wpos_q[chi]   <= '0;
    end else if (wr_en) begin
      wpos_q[chi] <= (wp == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp + PTR_W'(1);
      if (cnt < CNT_W'(WINDOW_DEPTH)) count_q[chi] <= cnt + CNT_W'(1);
    end
  end

  // sample memory: one write port, one registered read port
  assign wr_en = cmd_i.do_submit && ch_ok && in_range;
  assign waddr = ADDR_W'(32'(chi) * WINDOW_DEPTH + 32'(wp));
  assign raddr = ADDR_W'(32'(chi) * WINDOW_DEPTH + 32'(idx_q[PTR_W-1:0]));

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[waddr] <= item_q.sample_value;
    rd_q <= mem_q[raddr];
  end

  // sum pass and deviation pass sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      rdv_q <= 1'b0;
      ph_q  <= PH_READ;
      n_q   <= '0;
    end else if (cmd_i.rd_start) begin
      idx_q <= '0;
      rdv_q <= 1'b0;
      n_q   <= cnt;
    end else if (cmd_i.sum_run) begin
      rdv_q <= idx_q < n_q;
      if (idx_q < n_q) idx_q <= idx_q + CNT_W'(1);
    end else if (cmd_i.dev_start) begin
      idx_q <= '0;
      ph_q  <= PH_READ;
    end else if (cmd_i.dev_run) begin
      case (ph_q)
        PH_READ: begin
          if (idx_q < n_q) begin
            idx_q <= idx_q + CNT_W'(1);
            ph_q  <= PH_DIFF;
          end
        end
        PH_DIFF: ph_q <= PH_HH;
        PH_HH:   ph_q <= PH_HL;
        PH_HL:   ph_q <= PH_LL;
        PH_LL:   ph_q <= PH_ACC;
        default: ph_q <= PH_READ;
      endcase
    end
  end

  assign nx   = $signed({1'b0, n_q}) * rd_q;
  assign diff = nx - s1_q;

  always_comb begin
    mul_a = HW'(e_q >> HW);
    mul_b = HW'(e_q >> HW);
    case (ph_q)
      PH_HL:   mul_b = e_q[HW-1:0];
      PH_LL: begin
        mul_a = e_q[HW-1:0];
        mul_b = e_q[HW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    nn_q <= n_q * n_q;
    k_q  <= K_W'(nn_q * (n_q - CNT_W'(1)));
    if (cmd_i.rd_start) begin
      s1_q   <= '0;
      mean_q <= '0;
    end else if (cmd_i.sum_run && rdv_q) begin
      s1_q <= s1_q + S_W'(rd_q);
    end
    if (cmd_i.dev_start) begin
      acc_q <= '0;
    end else if (cmd_i.dev_run) begin
      case (ph_q)
        PH_DIFF: e_q <= diff[EW] ? EW'(-diff) : EW'(diff);
        PH_HH:   prod_q <= mul_a * mul_b;
        PH_HL: begin
          acc_q  <= acc_q + (E_W'(prod_q) << (2 * HW));
          prod_q <= mul_a * mul_b;
        end
        PH_LL: begin
          acc_q  <= acc_q + (E_W'(prod_q) << (HW + 1));
          prod_q <= mul_a * mul_b;
        end
        PH_ACC:  acc_q <= acc_q + E_W'(prod_q);
        default: ;
      endcase
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        DIV_MEAN:  mean_q  <= div_neg ? -quot[31:0] : quot[31:0];
        DIV_STD:   sat_q   <= |quot[DIV_NW-1:SQ_W];
        DIV_CV:    cv_q    <= sat_signed(quot, div_neg);
        default:   ratio_q <= sat_signed(quot, div_neg);
      endcase
    end
    if (cmd_i.sd_take) begin
      sd_q  <= sdn;
      cvp_q <= sdn * CV_SCALE;
    end
  end

  // divider operands; rounded divisions use (2a + b) / 2b
  assign s1_mag = s1_q[S_W-1] ? S_W'(-s1_q) : S_W'(s1_q);
  assign m_mag  = mean_q[31] ? -mean_q : mean_q;
  assign t_mag  = tgt[31] ? -tgt : tgt;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_MEAN: begin
        div_num = (DIV_NW'(s1_mag) << 1) + DIV_NW'(n_q);
        div_den = DIV_DW'({n_q, 1'b0});
        div_neg = s1_q[S_W-1];
      end
      DIV_STD: begin
        div_num = acc_q;
        div_den = DIV_DW'(k_q);
        div_neg = 1'b0;
      end
      DIV_CV: begin
        div_num = (DIV_NW'(cvp_q) << 1) + DIV_NW'(m_mag);
        div_den = {m_mag, 1'b0};
        div_neg = mean_q[31];
      end
      default: begin
        div_num = (DIV_NW'(m_mag) << 17) + DIV_NW'(t_mag);
        div_den = {t_mag, 1'b0};
        div_neg = mean_q[31] ^ tgt[31];
      end
    endcase
  end

  qcws_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  qcws_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .x_i     (quot[SQ_W-1:0]),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  assign sdn = sat_q ? {SD_W{1'b1}} : root;

  // result assembly
  always_comb begin
    res = '0;
    case (cmd_i.res)
      RES_ACK: begin
        res.status       = ST_OK;
        res.sample_count = 5'(cnt);
      end
      RES_REJECT: begin
        res.status       = ST_REJECT;
        res.sample_count = 5'(cnt);
      end
      RES_BADQ:    res.status = ST_INVALID;
      RES_INVALID: begin
        res.status       = ST_INVALID;
        res.sample_count = 5'(n_q);
        res.mean_value   = mean_q;
      end
      RES_STATS: begin
        res.status       = ST_OK;
        res.sample_count = 5'(n_q);
        res.mean_value   = mean_q;
        res.std_dev      = sd_q;
        res.cv_percent   = cv_q;
        res.target_ratio = ratio_q;
      end
      default: res.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.kind      = item_q.kind;
  assign stat_o.ch_ok     = ch_ok;
  assign stat_o.in_range  = in_range;
  assign stat_o.n_zero    = (n_q == '0);
  assign stat_o.stats_ok  = (n_q >= CNT_W'(2)) && (mean_q != '0) && (tgt != '0);
  assign stat_o.sum_done  = (idx_q == n_q) && !rdv_q;
  assign stat_o.dev_done  = (idx_q == n_q) && (ph_q == PH_READ);
  assign stat_o.div_busy  = div_busy;
  assign stat_o.sqrt_busy = sqrt_busy;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_ok |-> (count_q[chi] <= CNT_W'(WINDOW_DEPTH)))
    else $error("sample count above window depth");

endmodule

// ===== sv/qcws_ctrl.sv =====
// ----------------------------------------------------------------------------
// qcws_ctrl
// Sequencer: decodes each item and steps the datapath through a query.
// ----------------------------------------------------------------------------
module qcws_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  qcws_pkg::stat_t  stat_i,
  output qcws_pkg::cmd_t   cmd_o
);
  import qcws_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_EXEC  = 13'h0002,
    S_SUM   = 13'h0004,
    S_MEAN  = 13'h0008,
    S_CHECK = 13'h0010,
    S_DEV   = 13'h0020,
    S_STD   = 13'h0040,
    S_SQRT  = 13'h0080,
    S_CVP   = 13'h0100,
    S_CV    = 13'h0200,
    S_RGO   = 13'h0400,
    S_RATIO = 13'h0800,
    S_OUT   = 13'h1000
  } state_e;

  state_e state_q, state_d;
  res_e   res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= RES_NONE;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    cmd_o.res = res_q;
    state_d = state_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_OUT;
        if (!stat_i.ch_ok) begin
          res_d = (stat_i.kind == KIND_QUERY) ? RES_BADQ : RES_NONE;
        end else begin
          case (stat_i.kind)
            KIND_SETUP: begin
              cmd_o.do_setup = 1'b1;
              res_d = RES_ACK;
            end
            KIND_SUBMIT: begin
              cmd_o.do_submit = 1'b1;
              res_d = stat_i.in_range ? RES_ACK : RES_REJECT;
            end
            KIND_QUERY: begin
              cmd_o.rd_start = 1'b1;
              state_d = S_SUM;
            end
            default: res_d = RES_NONE;
          endcase
        end
      end
      S_SUM: begin
        cmd_o.sum_run = 1'b1;
        cmd_o.div_sel = DIV_MEAN;
        if (stat_i.sum_done) begin
          if (stat_i.n_zero) begin
            res_d   = RES_INVALID;
            state_d = S_OUT;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d = S_MEAN;
          end
        end
      end
      S_MEAN: begin
        cmd_o.div_sel = DIV_MEAN;
        if (!stat_i.div_busy) begin
          cmd_o.div_take = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.stats_ok) begin
          cmd_o.dev_start = 1'b1;
          state_d = S_DEV;
        end else begin
          res_d   = RES_INVALID;
          state_d = S_OUT;
        end
      end
      S_DEV: begin
        cmd_o.dev_run = 1'b1;
        cmd_o.div_sel = DIV_STD;
        if (stat_i.dev_done) begin
          cmd_o.div_start = 1'b1;
          state_d = S_STD;
        end
      end
      S_STD: begin
        cmd_o.div_sel = DIV_STD;
        if (!stat_i.div_busy) begin
          cmd_o.div_take   = 1'b1;
          cmd_o.sqrt_start = 1'b1;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!stat_i.sqrt_busy) begin
          cmd_o.sd_take = 1'b1;
          state_d = S_CVP;
        end
      end
      S_CVP: begin
        cmd_o.div_sel   = DIV_CV;
        cmd_o.div_start = 1'b1;
        state_d = S_CV;
      end
      S_CV: begin
        cmd_o.div_sel = DIV_CV;
        if (!stat_i.div_busy) begin
          cmd_o.div_take = 1'b1;
          state_d = S_RGO;
        end
      end
      S_RGO: begin
        cmd_o.div_sel   = DIV_RATIO;
        cmd_o.div_start = 1'b1;
        state_d = S_RATIO;
      end
      S_RATIO: begin
        cmd_o.div_sel = DIV_RATIO;
        if (!stat_i.div_busy) begin
          cmd_o.div_take = 1'b1;
          res_d   = RES_STATS;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== sv/qc_window_statistics.sv =====
// ----------------------------------------------------------------------------
// qc_window_statistics
// Per-channel quality-control store with windowed mean, deviation and ratios.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : command items (submit sample, query, setup), valid/ready.
//   out_o : one result item per command, valid/ready, held in a register.
// Setup and submit items go through the execute and output states.
// A query walks the channel's window twice through the sample memory's
// read port (once for the sum, once for the squared deviations) and
// uses the shared one-bit-per-cycle divider four times (mean, variance,
// CV, ratio), plus the square root once.
// One item is worked on at a time; the next is accepted as soon as the
// previous result sits in the output register, even if not yet taken.
// If the receiver stalls, a finished result waits in the sequencer until
// the output register frees up, and no further item is taken meanwhile.
// Reset clears all targets, margins, counts and write positions at once;
// the sample memory is not cleared, queries only read written entries.
// ----------------------------------------------------------------------------
module qc_window_statistics (
  input  logic              clk_i,
  input  logic              rst_ni,
  qcws_in_if.sink           in_i,
  qcws_out_if.source        out_o
);
  import qcws_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: item decode and query stepping
  qcws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // tables, sample memory, arithmetic and result register
  qcws_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule
